// ----- src/ising_metropolis_spin_update_unit_macros.svh -----
`ifndef ISING_METROPOLIS_SPIN_UPDATE_UNIT_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_UNIT_MACROS_SVH

// same-cycle implication
`define ISINGM_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("isingm assertion failed");

// next-cycle implication
`define ISINGM_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("isingm assertion failed");

`endif

// ----- src/isingm_pkg.sv -----
`default_nettype none

package isingm_pkg;

  localparam int LATTICE_SIDE = 32;
  localparam int RANDOM_BITS  = 16;

  localparam int ADDR_W    = $clog2(LATTICE_SIDE);
  localparam int SITE_IN_W = 5;
  localparam int DRAW_W    = 16;
  localparam int THR_W     = 16;
  localparam int MAG_W     = 12;
  localparam int ENERGY_W  = 13;
  localparam int DE_W      = 6;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int CMP_W        = (RANDOM_BITS > DRAW_W) ? RANDOM_BITS : DRAW_W;
  localparam int THRESH_SHIFT = (RANDOM_BITS >= DRAW_W) ? RANDOM_BITS - DRAW_W : 0;
  localparam int DRAW_SHIFT   = (RANDOM_BITS >= DRAW_W) ? 0 : DRAW_W - RANDOM_BITS;
  localparam logic [DRAW_W-1:0] DRAW_MASK =
    (RANDOM_BITS >= DRAW_W) ? {DRAW_W{1'b1}} : DRAW_W'((1 << RANDOM_BITS) - 1);

  localparam logic signed [MAG_W-1:0] MAG_RESET =
    MAG_W'(LATTICE_SIDE * LATTICE_SIDE);
  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET =
    ENERGY_W'(-2 * LATTICE_SIDE * LATTICE_SIDE);
  localparam logic [THR_W-1:0] THR4_RESET = THR_W'(4555);
  localparam logic [THR_W-1:0] THR8_RESET = THR_W'(317);

  localparam logic signed [DE_W-1:0] DE_LOW  = 6'sd4;
  localparam logic signed [DE_W-1:0] DE_HIGH = 6'sd8;
  localparam logic signed [DE_W-1:0] DE_BIAS = 6'sd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_UP,
    ST_RD_DN,
    ST_RD_CUR
  } state_t;

  typedef enum logic [0:0] {
    REG_THR4 = 1'b0,
    REG_THR8 = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [THR_W-1:0] thr4;
    logic [THR_W-1:0] thr8;
  } thresholds_t;

  // reduce a raw coordinate modulo the lattice side
  function automatic logic [ADDR_W-1:0] wrap_site(input logic [SITE_IN_W-1:0] v);
    logic [SITE_IN_W:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (int'(t) >= LATTICE_SIDE) begin
        t = t - (SITE_IN_W + 1)'(LATTICE_SIDE);
      end
    end
    return ADDR_W'(t);
  endfunction

  function automatic logic [ADDR_W-1:0] step_back(input logic [ADDR_W-1:0] v);
    return (v == '0) ? ADDR_W'(LATTICE_SIDE - 1) : v - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] step_fwd(input logic [ADDR_W-1:0] v);
    return (v == ADDR_W'(LATTICE_SIDE - 1)) ? '0 : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- src/isingm_ram.sv -----
`default_nettype none

module isingm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/isingm_cfg.sv -----
`default_nettype none

module isingm_cfg import isingm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output thresholds_t           thr
);

  logic [THR_W-1:0] thr4_r, thr4_nxt;
  logic [THR_W-1:0] thr8_r, thr8_nxt;
  logic             wr_en;
  reg_sel_t         sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign sel        = reg_sel_t'(cfg_paddr[2]);

  always_comb begin
    thr4_nxt   = thr4_r;
    thr8_nxt   = thr8_r;
    cfg_prdata = '0;
    unique case (sel)
      REG_THR4: begin
        cfg_prdata = CFG_DATA_W'(thr4_r);
        if (wr_en) begin
          thr4_nxt = cfg_pwdata[THR_W-1:0];
        end
      end
      REG_THR8: begin
        cfg_prdata = CFG_DATA_W'(thr8_r);
        if (wr_en) begin
          thr8_nxt = cfg_pwdata[THR_W-1:0];
        end
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr4_r <= THR4_RESET;
      thr8_r <= THR8_RESET;
    end else begin
      thr4_r <= thr4_nxt;
      thr8_r <= thr8_nxt;
    end
  end

  assign thr.thr4 = thr4_r;
  assign thr.thr8 = thr8_r;

endmodule

`default_nettype wire

// ----- src/isingm_core.sv -----
`default_nettype none
`include "ising_metropolis_spin_update_unit_macros.svh"

module isingm_core import isingm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  thresholds_t            thr,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_flip_r;

  logic signed [MAG_W-1:0]    mag_r, mag_nxt;
  logic signed [ENERGY_W-1:0] energy_r, energy_nxt;

  logic [ADDR_W-1:0] row_r, col_r;
  logic [DRAW_W-1:0] draw_r;
  logic              up_bit_r, dn_bit_r;

  logic [SITE_IN_W-1:0] in_row, in_col;
  logic [DRAW_W-1:0]    in_draw;
  logic                 in_acc;

  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [LATTICE_SIDE-1:0] mem_wdata, mem_rdata, flip_row;

  logic                   spin, left_bit, right_bit, accept, commit;
  logic [2:0]             ones;
  logic signed [DE_W-1:0] twice_nsum, de;
  logic [CMP_W-1:0]       draw_cmp, thr4_cmp, thr8_cmp;

  assign in_row  = in_tdata[SITE_IN_W-1:0];
  assign in_col  = in_tdata[2*SITE_IN_W-1:SITE_IN_W];
  assign in_draw = in_tdata[2*SITE_IN_W +: DRAW_W];
  assign in_acc  = in_tvalid && in_tready;

  isingm_ram #(
    .WIDTH (LATTICE_SIDE),
    .DEPTH (LATTICE_SIDE)
  ) u_lattice (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // energy change from the current row word and the two latched neighbors
  assign spin      = mem_rdata[col_r];
  assign left_bit  = mem_rdata[step_back(col_r)];
  assign right_bit = mem_rdata[step_fwd(col_r)];
  assign ones      = {2'b00, up_bit_r} + {2'b00, dn_bit_r}
                   + {2'b00, left_bit} + {2'b00, right_bit};
  assign twice_nsum = $signed({1'b0, ones, 2'b00}) - DE_BIAS;
  assign de         = spin ? twice_nsum : -twice_nsum;

  assign draw_cmp = CMP_W'(draw_r & DRAW_MASK) << DRAW_SHIFT;
  assign thr4_cmp = CMP_W'(thr.thr4) << THRESH_SHIFT;
  assign thr8_cmp = CMP_W'(thr.thr8) << THRESH_SHIFT;

  assign accept = (de <= 0)
               || ((de == DE_LOW)  && (draw_cmp < thr4_cmp))
               || ((de == DE_HIGH) && (draw_cmp < thr8_cmp));

  assign flip_row = mem_rdata ^ (LATTICE_SIDE'(1) << col_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(LATTICE_SIDE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RD_UP;
        end
      end
      ST_RD_UP:  state_nxt = ST_RD_DN;
      ST_RD_DN:  state_nxt = ST_RD_CUR;
      ST_RD_CUR: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = row_r;
    mem_we    = 1'b0;
    mem_waddr = row_r;
    mem_wdata = flip_row;
    commit    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = in_tvalid;
        mem_raddr = step_back(wrap_site(in_row));
      end
      ST_RD_UP: begin
        mem_re    = 1'b1;
        mem_raddr = step_fwd(row_r);
      end
      ST_RD_DN: begin
        mem_re    = 1'b1;
        mem_raddr = row_r;
      end
      ST_RD_CUR: begin
        commit = !out_valid_r || out_tready;
        mem_we = commit && accept;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign clr_cnt_nxt = (state_r == ST_CLEAR) ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign mag_nxt    = (commit && accept)
                    ? mag_r + (spin ? -MAG_W'(2) : MAG_W'(2)) : mag_r;
  assign energy_nxt = (commit && accept) ? energy_r + ENERGY_W'(de) : energy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      mag_r       <= MAG_RESET;
      energy_r    <= ENERGY_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mag_r       <= mag_nxt;
      energy_r    <= energy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r  <= wrap_site(in_row);
      col_r  <= wrap_site(in_col);
      draw_r <= in_draw;
    end
    if (state_r == ST_RD_UP) begin
      up_bit_r <= mem_rdata[col_r];
    end
    if (state_r == ST_RD_DN) begin
      dn_bit_r <= mem_rdata[col_r];
    end
    if (commit) begin
      out_flip_r <= accept;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_flip_r;
  assign out_tdata  = {{(OUT_TDATA_W - MAG_W - ENERGY_W){1'b0}}, energy_r, mag_r};

  `ISINGM_ASSERT_NXT(a_accept_starts_read, clk, rst_n, in_acc, state_r == ST_RD_UP)
  `ISINGM_ASSERT_IMP(a_write_phase, clk, rst_n, mem_we,
                     state_r == ST_CLEAR || state_r == ST_RD_CUR)
  `ISINGM_ASSERT_IMP(a_mag_even, clk, rst_n, 1'b1, mag_r[0] == 1'b0)
  `ISINGM_ASSERT_IMP(a_energy_step, clk, rst_n, 1'b1, energy_r[1:0] == 2'b00)

endmodule

`default_nettype wire

// ----- src/ising_metropolis_spin_update_unit.sv -----
// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata: site_row, site_col, random_draw
// out_    | out | out_tvalid/out_tready | tdata: total_magnetization, total_energy;
//         |     |                     | tuser: flipped
// cfg_    | in  | psel/penable/pready | accept_threshold_4 @0x0, accept_threshold_8 @0x4
//
// Per item: three row reads from the lattice RAM (up row, down row, then the current row),
// then the row write-back and result load in ST_RD_CUR; the next item is taken after that.
// After reset a clearing pass sets all LATTICE_SIDE (32) rows of the lattice to +1, one row
// per cycle; in_tready stays low meanwhile, cfg writes are taken.
// A result waiting on out_tready does not block acceptance of the next item;
// only its write-back stage waits for the output register to free up.
`default_nettype none

module ising_metropolis_spin_update_unit import isingm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] site_row, [9:5] site_col, [25:10] random_draw, [31:26] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [11:0] total_magnetization, [24:12] total_energy, [31:25] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] flipped
  output logic                   out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  thresholds_t thr;

  isingm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  isingm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .thr        (thr),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- bench/ising_metropolis_spin_update_unit_tb.sv -----
module ising_metropolis_spin_update_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isingm_pkg::*;

  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int BATCH_COUNT  = 13;
  localparam int BATCH_ITEMS  = 100;

  typedef struct packed {
    logic                flipped;
    logic [MAG_W-1:0]    magnetization;
    logic [ENERGY_W-1:0] energy;
  } spin_update_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  ising_metropolis_spin_update_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lattice model, 1 = spin up
  bit                      spin_state [SITE_COUNT];
  int                      magnetization_total;
  int                      energy_total;
  logic [THR_W-1:0]        thr4_model;
  logic [THR_W-1:0]        thr8_model;

  logic [IN_TDATA_W-1:0]   pending_proposals [$];
  spin_update_t            expected_updates [$];
  int                      n_queued = 0;
  int                      n_accepted = 0;
  int                      mismatch_count = 0;
  int                      cycle_count = 0;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;

  function automatic int spin_value(int row, int col);
    return spin_state[row * LATTICE_SIDE + col] ? 1 : -1;
  endfunction

  function automatic spin_update_t metropolis_step(logic [SITE_IN_W-1:0] row_raw,
                                                   logic [SITE_IN_W-1:0] col_raw,
                                                   logic [DRAW_W-1:0] draw);
    int           row, col, s, nsum, de;
    logic         take;
    spin_update_t r;
    row  = int'(row_raw) % LATTICE_SIDE;
    col  = int'(col_raw) % LATTICE_SIDE;
    s    = spin_value(row, col);
    nsum = spin_value((row + LATTICE_SIDE - 1) % LATTICE_SIDE, col)
         + spin_value((row + 1) % LATTICE_SIDE, col)
         + spin_value(row, (col + LATTICE_SIDE - 1) % LATTICE_SIDE)
         + spin_value(row, (col + 1) % LATTICE_SIDE);
    de = 2 * s * nsum;
    if (de <= 0) begin
      take = 1'b1;
    end else if (de == 4) begin
      take = draw < thr4_model;
    end else begin
      take = draw < thr8_model;
    end
    if (take) begin
      spin_state[row * LATTICE_SIDE + col] = (s < 0);
      magnetization_total -= 2 * s;
      energy_total += de;
    end
    r.flipped       = take;
    r.magnetization = MAG_W'(magnetization_total);
    r.energy        = ENERGY_W'(energy_total);
    return r;
  endfunction

  task automatic queue_proposal(int row, int col, int draw);
    pending_proposals.push_back(IN_TDATA_W'({DRAW_W'(draw), SITE_IN_W'(col), SITE_IN_W'(row)}));
    n_queued++;
  endtask

  // sites cluster around the wrapped corner half the time so flips interact
  task automatic queue_random_proposal();
    int row, col, draw, pick;
    if ($urandom_range(1)) begin
      row = ($urandom_range(3) + LATTICE_SIDE - 2) % LATTICE_SIDE;
      col = ($urandom_range(3) + LATTICE_SIDE - 2) % LATTICE_SIDE;
    end else begin
      row = $urandom_range(LATTICE_SIDE - 1);
      col = $urandom_range(LATTICE_SIDE - 1);
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      draw = $urandom_range(65535);
    end else if (pick < 70) begin
      draw = ($urandom_range(1) ? int'(thr4_model) : int'(thr8_model)) + $urandom_range(4) - 2;
      if (draw < 0) draw = 0;
      if (draw > 65535) draw = 65535;
    end else if (pick < 85) begin
      draw = 0;
    end else begin
      draw = 65535;
    end
    queue_proposal(row, col, draw);
  endtask

  task automatic write_threshold(reg_sel_t sel, int value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({sel, 2'b00});
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (sel)
      REG_THR4: thr4_model = THR_W'(value);
      REG_THR8: thr8_model = THR_W'(value);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_updates.push_back(metropolis_step(
          in_tdata[SITE_IN_W-1:0],
          in_tdata[2*SITE_IN_W-1:SITE_IN_W],
          in_tdata[2*SITE_IN_W+DRAW_W-1:2*SITE_IN_W]));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_proposals.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_proposals.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    spin_update_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_updates.size() == 0) begin
          $error("result item with no pending expectation");
          mismatch_count++;
        end else begin
          want = expected_updates.pop_front();
          if (out_tuser !== want.flipped) begin
            $error("flipped: expected %0b, got %0b", want.flipped, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[MAG_W-1:0] !== want.magnetization) begin
            $error("total_magnetization: expected %0d, got %0d",
                   $signed(want.magnetization), $signed(out_tdata[MAG_W-1:0]));
            mismatch_count++;
          end
          if (out_tdata[MAG_W+ENERGY_W-1:MAG_W] !== want.energy) begin
            $error("total_energy: expected %0d, got %0d",
                   $signed(want.energy), $signed(out_tdata[MAG_W+ENERGY_W-1:MAG_W]));
            mismatch_count++;
          end
        end
      end
      out_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    foreach (spin_state[i]) spin_state[i] = 1'b1;
    magnetization_total = SITE_COUNT;
    energy_total        = -2 * SITE_COUNT;
    thr4_model          = THR4_RESET;
    thr8_model          = THR8_RESET;
    send_idle_pct       = 24;
    recv_idle_pct       = 64;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: boundary draws, dE of 8, -8, 4 and 0
    queue_proposal(0, 0, 0);
    queue_proposal(0, 0, 65535);
    queue_proposal(31, 31, 316);
    queue_proposal(31, 31, 0);
    queue_proposal(0, 31, 317);
    queue_proposal(31, 0, 65535);
    queue_proposal(0, 0, 0);
    queue_proposal(0, 1, 4554);
    queue_proposal(1, 0, 4555);
    queue_proposal(1, 1, 0);
    queue_proposal(1, 0, 65535);
    queue_proposal(0, 1, 65535);
    wait_drained();

    // full-scale threshold still rejects the top draw
    write_threshold(REG_THR4, 65535);
    write_threshold(REG_THR8, 65535);
    queue_proposal(15, 15, 65535);
    queue_proposal(15, 15, 65534);
    queue_proposal(15, 16, 65534);
    queue_proposal(15, 16, 65535);
    queue_proposal(16, 15, 65535);
    wait_drained();

    // zero threshold never accepts an uphill move
    write_threshold(REG_THR4, 0);
    write_threshold(REG_THR8, 0);
    queue_proposal(8, 8, 0);
    queue_proposal(15, 17, 0);
    queue_proposal(15, 15, 0);
    queue_proposal(0, 0, 0);
    wait_drained();

    for (int b = 0; b < BATCH_COUNT; b++) begin
      if (b < 5) begin
        send_idle_pct = 24;
        recv_idle_pct = 64;
      end else if (b < 9) begin
        send_idle_pct = 64;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (b % 6)
        0: begin
          write_threshold(REG_THR4, 65535);
          write_threshold(REG_THR8, 65535);
        end
        1: begin
          write_threshold(REG_THR4, 4555);
          write_threshold(REG_THR8, 317);
        end
        2: begin
          write_threshold(REG_THR4, 0);
          write_threshold(REG_THR8, 0);
        end
        3: begin
          write_threshold(REG_THR4, $urandom_range(65535));
          write_threshold(REG_THR8, $urandom_range(65535));
        end
        4: begin
          write_threshold(REG_THR4, 40000);
          write_threshold(REG_THR8, 12000);
        end
        default: begin
          write_threshold(REG_THR4, 65535);
          write_threshold(REG_THR8, 0);
        end
      endcase
      repeat (BATCH_ITEMS) queue_random_proposal();
      wait_drained();
    end

    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0 && expected_updates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
